FILE: rtl/tftprc_pkg.sv
// Shared types and codes for the TFTP read client step block.
package tftprc_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_REQUEST  = 2'd1,
        PH_OPTACKED = 2'd2,
        PH_TRANSFER = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE = 3'd0,
        ACT_RRQ  = 3'd1,
        ACT_ACK  = 3'd2,
        ACT_ERR  = 3'd3,
        ACT_DATA = 3'd4,
        ACT_FAIL = 3'd5
    } action_t;

    localparam logic [1:0]  REQ_START    = 2'd0;
    localparam logic [1:0]  REQ_PACKET   = 2'd1;
    localparam logic [1:0]  REQ_TIMEOUT  = 2'd2;
    localparam logic [1:0]  REQ_RESERVED = 2'd3;

    localparam logic [15:0] OP_DATA  = 16'd3;
    localparam logic [15:0] OP_ERROR = 16'd5;
    localparam logic [15:0] OP_OACK  = 16'd6;

    localparam logic ERRC_GENERIC  = 1'b0;
    localparam logic ERRC_SEQUENCE = 1'b1;

    localparam logic [1:0] CFG_MAX_TRIES     = 2'd0;
    localparam logic [1:0] CFG_REQUESTED_BSZ = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_BSZ   = 2'd2;

    localparam logic [3:0]  MAX_TRIES_RESET = 4'd10;
    localparam logic [11:0] REQ_BSZ_RESET   = 12'd1400;
    localparam logic [11:0] DEF_BSZ_RESET   = 12'd512;

    typedef struct packed {
        action_t     action;
        logic [15:0] ack_block;
        logic        error_code;
        logic [11:0] data_length;
        logic [11:0] block_size;
        logic        last;
    } result_t;

    // One queue entry: the results caused by one input item.
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

endpackage

FILE: rtl/tftprc_front.sv
// Front end: takes items, classifies them against the transfer state, builds results.
module tftprc_front #(
    parameter int MAX_SEG = 2048
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [1:0]           req_type,
    input  logic [15:0]          opcode,
    input  logic [15:0]          block_number,
    input  logic [11:0]          payload_length,
    input  logic [15:0]          offered_block_size,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [11:0]          cfg_data,
    output tftprc_pkg::entry_t   entry
);
    import tftprc_pkg::*;

    localparam int SEG_NEED = $clog2(MAX_SEG + 1);
    localparam int SEG_W    = (SEG_NEED > 12) ? SEG_NEED : 12;

    typedef enum logic [3:0] {
        EV_START,
        EV_NONE,
        EV_RETRY,
        EV_GIVEUP,
        EV_FAIL,
        EV_OACK,
        EV_ERR_GEN,
        EV_ERR_SEQ,
        EV_DATA_FIRST,
        EV_DATA_NEXT
    } event_t;

    logic [3:0]       max_tries_reg;
    logic [11:0]      req_bsz_reg;
    logic [11:0]      def_bsz_reg;

    phase_t           phase_reg, phase_next;
    logic [15:0]      expected_reg, expected_next;
    logic [3:0]       try_reg, try_next;
    logic [SEG_W-1:0] seg_reg, seg_next;

    event_t           ev;
    logic             exhausted;
    logic             size_ok;
    logic [15:0]      blk_next;
    logic [SEG_W-1:0] cap;
    logic [SEG_W-1:0] plen_ext;
    logic [SEG_W-1:0] dlen;
    logic             short_blk;
    result_t          base;

    assign exhausted = (try_reg >= max_tries_reg);
    assign size_ok   = (offered_block_size != 16'd0) &&
                       (offered_block_size <= 16'(MAX_SEG));
    assign blk_next  = expected_reg + 16'd1;
    assign cap       = (ev == EV_DATA_FIRST) ? SEG_W'(MAX_SEG) : seg_reg;
    assign plen_ext  = SEG_W'(payload_length);
    assign dlen      = (plen_ext > cap) ? cap : plen_ext;
    assign short_blk = (dlen < seg_reg);

    // Classification
    always_comb
    begin
        if (req_type == REQ_START)
            ev = EV_START;
        else if (phase_reg == PH_IDLE || req_type == REQ_RESERVED)
            ev = EV_NONE;
        else if (req_type == REQ_TIMEOUT)
            ev = exhausted ? EV_GIVEUP : EV_RETRY;
        else if (phase_reg != PH_TRANSFER)
        begin
            if (opcode == OP_ERROR)
                ev = EV_FAIL;
            else if (opcode == OP_OACK)
                ev = size_ok ? EV_OACK : EV_ERR_GEN;
            else if (opcode == OP_DATA)
                ev = (block_number == 16'd1) ? EV_DATA_FIRST : EV_ERR_SEQ;
            else
                ev = EV_ERR_GEN;
        end
        else if (opcode != OP_DATA)
            ev = EV_ERR_GEN;
        else if (block_number == blk_next)
            ev = EV_DATA_NEXT;
        else
            ev = exhausted ? EV_GIVEUP : EV_RETRY;
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (ev)
            EV_START:                           phase_next = PH_REQUEST;
            EV_GIVEUP, EV_FAIL,
            EV_ERR_GEN, EV_ERR_SEQ:             phase_next = PH_IDLE;
            EV_OACK:                            phase_next = PH_OPTACKED;
            EV_DATA_FIRST, EV_DATA_NEXT:
                phase_next = short_blk ? PH_IDLE : PH_TRANSFER;
            default:                            phase_next = phase_reg;
        endcase
    end

    // Counters and negotiated size
    always_comb
    begin
        expected_next = expected_reg;
        try_next      = try_reg;
        seg_next      = seg_reg;
        unique case (ev)
            EV_START:
            begin
                expected_next = 16'd0;
                try_next      = 4'd1;
                seg_next      = SEG_W'(def_bsz_reg);
            end
            EV_RETRY:
                try_next = (try_reg != 4'd15) ? try_reg + 4'd1 : try_reg;
            EV_OACK:
            begin
                try_next = 4'd1;
                seg_next = offered_block_size[SEG_W-1:0];
            end
            EV_DATA_FIRST:
            begin
                expected_next = 16'd1;
                try_next      = 4'd1;
            end
            EV_DATA_NEXT:
            begin
                expected_next = blk_next;
                try_next      = 4'd1;
            end
            default: ;
        endcase
    end

    // Result builder
    always_comb
    begin
        base             = '0;
        base.action      = ACT_NONE;
        base.block_size  = seg_reg[11:0];
        base.last        = 1'b1;
        entry            = '0;
        entry.r0         = base;
        entry.r1         = base;
        entry.r1.action  = ACT_FAIL;
        unique case (ev)
            EV_START:
            begin
                entry.r0.action     = ACT_RRQ;
                entry.r0.block_size = req_bsz_reg;
            end
            EV_NONE: ;
            EV_GIVEUP, EV_FAIL:
                entry.r0.action = ACT_FAIL;
            EV_RETRY:
            begin
                if (phase_reg == PH_REQUEST)
                begin
                    entry.r0.action     = ACT_RRQ;
                    entry.r0.block_size = req_bsz_reg;
                end
                else
                begin
                    entry.r0.action    = ACT_ACK;
                    entry.r0.ack_block = (phase_reg == PH_TRANSFER) ? expected_reg : 16'd0;
                end
            end
            EV_OACK:
            begin
                entry.r0.action     = ACT_ACK;
                entry.r0.block_size = offered_block_size[11:0];
            end
            EV_ERR_GEN, EV_ERR_SEQ:
            begin
                entry.two           = 1'b1;
                entry.r0.action     = ACT_ERR;
                entry.r0.error_code = (ev == EV_ERR_SEQ) ? ERRC_SEQUENCE : ERRC_GENERIC;
                entry.r0.last       = 1'b0;
            end
            EV_DATA_FIRST, EV_DATA_NEXT:
            begin
                entry.two            = 1'b1;
                entry.r0.action      = ACT_DATA;
                entry.r0.data_length = dlen[11:0];
                entry.r0.last        = short_blk;
                entry.r1.action      = ACT_ACK;
                entry.r1.ack_block   = (ev == EV_DATA_FIRST) ? 16'd1 : blk_next;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tries_reg <= MAX_TRIES_RESET;
            req_bsz_reg   <= REQ_BSZ_RESET;
            def_bsz_reg   <= DEF_BSZ_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MAX_TRIES:     max_tries_reg <= cfg_data[3:0];
                CFG_REQUESTED_BSZ: req_bsz_reg   <= cfg_data;
                CFG_DEFAULT_BSZ:   def_bsz_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            expected_reg <= 16'd0;
            try_reg      <= 4'd0;
            seg_reg      <= SEG_W'(DEF_BSZ_RESET);
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            expected_reg <= expected_next;
            try_reg      <= try_next;
            seg_reg      <= seg_next;
        end
    end

    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req_type == REQ_START |=> phase_reg == PH_REQUEST && try_reg == 4'd1)
        else $error("start item did not arm the request phase");

    a_data_resets_tries: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (ev == EV_DATA_FIRST || ev == EV_DATA_NEXT) |=> try_reg == 4'd1)
        else $error("delivered block did not reset try count");

endmodule

FILE: rtl/tftprc_queue.sv
// Short result queue between the front end and the output stage.
module tftprc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tftprc_pkg::entry_t  wr_entry,
    input  logic                pop,
    output tftprc_pkg::entry_t  rd_entry,
    output logic                full,
    output logic                empty
);
    import tftprc_pkg::*;

    entry_t              mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign full     = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("pop from empty queue");

endmodule

FILE: rtl/tftprc_back.sv
// Output stage: holds one queue entry and sends its one or two results as beats.
module tftprc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tftprc_pkg::entry_t  head,
    input  logic                empty,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata,
    output logic [2:0]          m_tuser,
    output logic                m_tlast
);
    import tftprc_pkg::*;

    entry_t  entry_reg;
    logic    valid_reg;
    logic    sel_reg;
    logic    out_free;
    logic    second;
    result_t cur;

    assign out_free = !valid_reg || m_tready;
    assign second   = valid_reg && m_tready && !sel_reg && entry_reg.two;
    assign pop      = out_free && !empty && !second;

    assign cur      = sel_reg ? entry_reg.r1 : entry_reg.r0;
    assign m_tvalid = valid_reg;
    assign m_tuser  = cur.action;
    assign m_tlast  = cur.last;
    assign m_tdata  = {7'd0, cur.block_size, cur.data_length, cur.error_code, cur.ack_block};

    always_ff @(posedge clk)
    begin
        if (pop)
            entry_reg <= head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else if (second)
            sel_reg <= 1'b1;
        else if (out_free)
        begin
            valid_reg <= !empty;
            sel_reg   <= 1'b0;
        end
    end

    a_second_only_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && sel_reg |-> entry_reg.two)
        else $error("second beat shown for a single-result entry");

endmodule

FILE: rtl/tftp_read_client_step_top.sv
// Top level of the TFTP read client step block.
//
//  channel   direction  handshake             payload
//  s_*       in         s_tvalid / s_tready   tuser req_type, tdata packet header fields
//  m_*       out        m_tvalid / m_tready   tuser action, tdata result fields, tlast last
//  cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle enters while the queue is not full; the front end updates state in the cycle it accepts.
// An item that causes two results takes two output beats; the first result is
// offered at the earliest after the queue write and then the output register.
// Reset clears state, empties the queue and loads register defaults; no sweep.
// Input stalls only when the four-entry queue is full; cfg_ready is always high.
module tftp_read_client_step_top #(
    parameter int MAX_SEG = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // opcode, block_number, payload_length, offered_block_size
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // ack_block, error_code, data_length, block_size
    output logic [2:0]  m_tuser,   // action
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    import tftprc_pkg::*;

    entry_t new_entry;
    entry_t head_entry;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;
    logic   accept;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    tftprc_front #(
        .MAX_SEG(MAX_SEG)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .req_type           (s_tuser),
        .opcode             (s_tdata[15:0]),
        .block_number       (s_tdata[31:16]),
        .payload_length     (s_tdata[43:32]),
        .offered_block_size (s_tdata[59:44]),
        .cfg_write          (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .entry              (new_entry)
    );

    tftprc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .wr_entry (new_entry),
        .pop      (q_pop),
        .rd_entry (head_entry),
        .full     (q_full),
        .empty    (q_empty)
    );

    tftprc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head_entry),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
